### rtl/qte_pkg.sv
package qte_pkg;

	// Number of CORDIC rotations, limited by the length of the arctangent table.
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	// Integer square root of a 57-bit radicand, one result bit per step.
	localparam int ISQRT_STEPS = 29;
	localparam int RAD_W       = 57;
	localparam int RES_W       = 58;

	localparam int IDX_W = 5;   // stage index width
	localparam int VW    = 56;  // CORDIC vector width
	localparam int OPW   = 34;  // atan2 operand width
	localparam int SW    = 30;  // clamped sine width

	localparam logic signed [OPW-1:0] UNIT_Q28 = OPW'(64'sd268435456);
	localparam logic signed [16:0] PITCH_MAX   = 17'sd16384;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic [31:0]          z;
		logic                 zero;
	} cordic_t;

	typedef struct packed {
		logic [RAD_W-1:0] n;
		logic [RES_W-1:0] r;
	} isqrt_t;

	function automatic logic [31:0] atan_bam(input logic [IDX_W-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	// Prepares an atan2 operand pair: zero detect, turn by pi for a
	// negative x, and lift by 2^20.
	function automatic cordic_t cordic_init(input logic signed [OPW-1:0] y,
			input logic signed [OPW-1:0] x);
		cordic_t c;
		logic signed [VW-1:0] xe;
		logic signed [VW-1:0] ye;
		xe = VW'(x);
		ye = VW'(y);
		c.zero = (x == '0) && (y == '0);
		c.z = 32'd0;
		if (x < 0) begin
			xe = -xe;
			ye = -ye;
			c.z = 32'h8000_0000;
		end
		c.x = xe <<< 20;
		c.y = ye <<< 20;
		return c;
	endfunction

	// Round a 32-bit binary angle to 16 bits; the wider result keeps +pi.
	function automatic logic signed [16:0] round16(input logic [31:0] z);
		logic signed [32:0] t;
		t = 33'(signed'(z)) + 33'sd32768;
		return t[32:16];
	endfunction

endpackage

### rtl/qte_front.sv
module qte_front import qte_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [15:0]      q_w,
	input  logic signed [15:0]      q_x,
	input  logic signed [15:0]      q_y,
	input  logic signed [15:0]      q_z,
	output cordic_t                 yaw_init,
	output cordic_t                 roll_init,
	output logic [RAD_W-1:0]        rad,
	output logic signed [SW-1:0]    sine,
	output logic                    clamp
);

	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, yz_s1, wx_s1, wy_s1, xz_s1;
	logic signed [OPW-1:0] yaw_y_s2, yaw_x_s2, roll_y_s2, roll_x_s2;
	logic signed [SW-1:0] sine_s2;
	logic clamp_s2;
	logic signed [OPW-1:0] sine_full;
	logic signed [32:0] t_yaw, t_roll, t_sin;
	logic [59:0] sq;

	cordic_t yaw_s3, roll_s3;
	logic [RAD_W-1:0] rad_s3;
	logic signed [SW-1:0] sine_s3;
	logic clamp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= q_w * q_w;
			xx_s1 <= q_x * q_x;
			yy_s1 <= q_y * q_y;
			zz_s1 <= q_z * q_z;
			xy_s1 <= q_x * q_y;
			wz_s1 <= q_w * q_z;
			yz_s1 <= q_y * q_z;
			wx_s1 <= q_w * q_x;
			wy_s1 <= q_w * q_y;
			xz_s1 <= q_x * q_z;
		end
	end

	always_comb begin
		t_yaw = 33'(xy_s1) + 33'(wz_s1);
		t_roll = 33'(yz_s1) + 33'(wx_s1);
		t_sin = 33'(wy_s1) - 33'(xz_s1);
		sine_full = {t_sin, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_y_s2 <= {t_yaw, 1'b0};
			roll_y_s2 <= {t_roll, 1'b0};
			yaw_x_s2 <= OPW'(ww_s1) + OPW'(xx_s1) - OPW'(yy_s1) - OPW'(zz_s1);
			roll_x_s2 <= OPW'(ww_s1) - OPW'(xx_s1) - OPW'(yy_s1) + OPW'(zz_s1);
			if (sine_full > UNIT_Q28) begin
				sine_s2 <= SW'(UNIT_Q28);
				clamp_s2 <= 1'b1;
			end else if (sine_full < -UNIT_Q28) begin
				sine_s2 <= SW'(-UNIT_Q28);
				clamp_s2 <= 1'b1;
			end else begin
				sine_s2 <= SW'(sine_full);
				clamp_s2 <= 1'b0;
			end
		end
	end

	// The square of the sine is never negative.
	assign sq = 60'(sine_s2) * 60'(sine_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s3 <= cordic_init(yaw_y_s2, yaw_x_s2);
			roll_s3 <= cordic_init(roll_y_s2, roll_x_s2);
			rad_s3 <= RAD_W'((60'd1 << 56) - sq);
			sine_s3 <= sine_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	assign yaw_init = yaw_s3;
	assign roll_init = roll_s3;
	assign rad = rad_s3;
	assign sine = sine_s3;
	assign clamp = clamp_s3;

endmodule

### rtl/qte_isqrt_cell.sv
module qte_isqrt_cell import qte_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [IDX_W-1:0] stage,
	input  isqrt_t           d,
	output isqrt_t           cell_q
);

	logic [5:0] sh;
	logic [RES_W-1:0] bit_v;
	logic [RES_W-1:0] sum;
	isqrt_t nxt;

	always_comb begin
		sh = 6'(2 * (ISQRT_STEPS - 1)) - {stage, 1'b0};
		bit_v = RES_W'(1) << sh;
		sum = d.r + bit_v;
		nxt = d;
		if ({1'b0, d.n} >= sum) begin
			nxt.n = d.n - RAD_W'(sum);
			nxt.r = (d.r >> 1) + bit_v;
		end else begin
			nxt.r = d.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

endmodule

### rtl/qte_cordic_cell.sv
module qte_cordic_cell import qte_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [IDX_W-1:0] stage,
	input  cordic_t          d,
	output cordic_t          cell_q
);

	logic signed [VW-1:0] xi, yi, dx, dy;
	cordic_t nxt;

	always_comb begin
		xi = d.x;
		yi = d.y;
		dx = yi >>> stage;
		dy = xi >>> stage;
		nxt = d;
		if (yi >= 0) begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = d.z + atan_bam(stage);
		end else begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = d.z - atan_bam(stage);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

endmodule

### rtl/quaternion_to_euler_zyx.sv
// Throughput: one request per clock; the whole pipe advances together and only
// stalls when a finished result waits at the output and m_tready is low.
// The pitch path sets the latency: a 29-step square root chain, then CORDIC.
// Reset (arst_n low, asynchronous) clears all valid flags; data registers are not reset.
module quaternion_to_euler_zyx import qte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // yaw_angle[15:0], pitch_angle[31:16], roll_angle[47:32]
	output logic        m_tuser    // pitch_clamped
);

	localparam int DLY = ISQRT_STEPS + 1;
	localparam int LAT = 3 + ISQRT_STEPS + 1 + CORDIC_N + 1;

	logic en;
	logic [LAT-1:0] vld_q;

	cordic_t yaw_c [0:CORDIC_N];
	cordic_t roll_c [0:CORDIC_N];
	cordic_t pit_c [0:CORDIC_N];
	cordic_t pit_init_q;
	isqrt_t sq_c [0:ISQRT_STEPS];

	logic [RAD_W-1:0] rad;
	logic signed [SW-1:0] sine;
	logic clamp;

	logic signed [SW-1:0] sine_dly_q [1:ISQRT_STEPS];
	logic [32:0] yaw_dly_q [1:DLY];
	logic [32:0] roll_dly_q [1:DLY];
	logic [DLY+CORDIC_N-1:0] clamp_dly_q;

	logic signed [16:0] yaw_r, pit_r, roll_r;
	logic [15:0] pit_sat;
	logic [47:0] out_q;
	logic user_q;

	// The whole pipe moves whenever the output slot is free or being emptied.
	assign en = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Products, sums, clamping of the sine and the radicand 1 - s^2.
	qte_front u_front (
		.clk       (clk),
		.en        (en),
		.q_w       (s_tdata[15:0]),
		.q_x       (s_tdata[31:16]),
		.q_y       (s_tdata[47:32]),
		.q_z       (s_tdata[63:48]),
		.yaw_init  (yaw_c[0]),
		.roll_init (roll_c[0]),
		.rad       (rad),
		.sine      (sine),
		.clamp     (clamp)
	);

	// Square root chain: each cell settles one bit of cos(pitch).
	assign sq_c[0] = '{n: rad, r: '0};

	for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_isqrt
		qte_isqrt_cell u_cell (
			.clk    (clk),
			.en     (en),
			.stage  (IDX_W'(k)),
			.d      (sq_c[k]),
			.cell_q (sq_c[k+1])
		);
	end

	// The sine travels beside the square root chain.
	always_ff @(posedge clk) begin
		if (en) begin
			sine_dly_q[1] <= sine;
			for (int i = 2; i <= ISQRT_STEPS; i++) begin
				sine_dly_q[i] <= sine_dly_q[i-1];
			end
		end
	end

	// Pitch is atan2(sine, cosine) once the cosine is known.
	always_ff @(posedge clk) begin
		if (en) begin
			pit_init_q <= cordic_init(OPW'(sine_dly_q[ISQRT_STEPS]),
				signed'({5'd0, sq_c[ISQRT_STEPS].r[28:0]}));
		end
	end

	assign pit_c[0] = pit_init_q;

	// Three rows of rotation cells, one rotation per cell.
	for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
		qte_cordic_cell u_yaw (
			.clk    (clk),
			.en     (en),
			.stage  (IDX_W'(k)),
			.d      (yaw_c[k]),
			.cell_q (yaw_c[k+1])
		);
		qte_cordic_cell u_roll (
			.clk    (clk),
			.en     (en),
			.stage  (IDX_W'(k)),
			.d      (roll_c[k]),
			.cell_q (roll_c[k+1])
		);
		qte_cordic_cell u_pitch (
			.clk    (clk),
			.en     (en),
			.stage  (IDX_W'(k)),
			.d      (pit_c[k]),
			.cell_q (pit_c[k+1])
		);
	end

	// Yaw and roll finish early and wait here for the pitch of the same request.
	always_ff @(posedge clk) begin
		if (en) begin
			yaw_dly_q[1] <= {yaw_c[CORDIC_N].z, yaw_c[CORDIC_N].zero};
			roll_dly_q[1] <= {roll_c[CORDIC_N].z, roll_c[CORDIC_N].zero};
			for (int i = 2; i <= DLY; i++) begin
				yaw_dly_q[i] <= yaw_dly_q[i-1];
				roll_dly_q[i] <= roll_dly_q[i-1];
			end
			clamp_dly_q <= {clamp_dly_q[DLY+CORDIC_N-2:0], clamp};
		end
	end

	// Rounding to 16-bit angles, pitch saturated to +-90 deg; an input pair of zeros gives angle zero.
	always_comb begin
		yaw_r = yaw_dly_q[DLY][0] ? 17'sd0 : round16(yaw_dly_q[DLY][32:1]);
		roll_r = roll_dly_q[DLY][0] ? 17'sd0 : round16(roll_dly_q[DLY][32:1]);
		pit_r = pit_c[CORDIC_N].zero ? 17'sd0 : round16(pit_c[CORDIC_N].z);
		if (pit_r > PITCH_MAX) begin
			pit_sat = 16'(PITCH_MAX);
		end else if (pit_r < -PITCH_MAX) begin
			pit_sat = 16'(-PITCH_MAX);
		end else begin
			pit_sat = pit_r[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= {roll_r[15:0], pit_sat, yaw_r[15:0]};
			user_q <= clamp_dly_q[DLY+CORDIC_N-1];
		end
	end

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata = out_q;
	assign m_tuser = user_q;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import qte_pkg::*;

	// Pipeline depth of the block; used for the drain at the end.
	localparam int PIPE_DEPTH = 34 + CORDIC_N;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_REQUESTS = 800;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // yaw_angle[15:0], pitch_angle[31:16], roll_angle[47:32]
	logic        m_tuser;   // pitch_clamped

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic               clamped;
	} euler_t;

	// A directed row: the quaternion, and optionally a hand-read answer.
	typedef struct {
		quat_t  q;
		bit     known;
		euler_t e;
	} vector_row_t;

	quaternion_to_euler_zyx u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	euler_t angles_pending[$];
	int     error_count;
	int     idle_cycles;
	bit     long_hold;
	bit     stimulus_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] atan_table(input int i);
		logic [31:0] t[24];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
			32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
			32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
			32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
		return t[i];
	endfunction

	// Vectoring CORDIC atan2 returning a 32-bit binary angle (2^31 = pi).
	function automatic logic [31:0] atan2_bam(input longint signed ay, input longint signed ax);
		logic [31:0] ang;
		longint signed vx;
		longint signed vy;
		longint signed sx;
		longint signed sy;
		ang = 32'd0;
		vx = ax;
		vy = ay;
		if (vx == 0 && vy == 0) begin
			return 32'd0;
		end
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			ang = 32'h8000_0000;
		end
		vx = vx * (64'sd1 <<< 20);
		vy = vy * (64'sd1 <<< 20);
		for (int i = 0; i < CORDIC_N; i++) begin
			// >>> on a signed longint is an arithmetic shift, as required.
			sx = vy >>> i;
			sy = vx >>> i;
			if (vy >= 0) begin
				vx = vx + sx;
				vy = vy - sy;
				ang = ang + atan_table(i);
			end else begin
				vx = vx - sx;
				vy = vy + sy;
				ang = ang - atan_table(i);
			end
		end
		return ang;
	endfunction

	// Round to nearest 16-bit binary angle; the longint result keeps +pi.
	function automatic longint signed bam_to16(input logic [31:0] ang);
		longint signed v;
		v = longint'(signed'(ang));
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic euler_t euler_from_quat(input quat_t q);
		euler_t e;
		longint signed w;
		longint signed x;
		longint signed y;
		longint signed z;
		longint signed sine;
		longint signed cosine;
		longint signed p;
		longint signed unit;
		w = q.w;
		x = q.x;
		y = q.y;
		z = q.z;
		unit = 64'sd1 <<< 28;
		e.clamped = 1'b0;
		sine = 2 * (w * y - x * z);
		if (sine > unit) begin
			sine = unit;
			e.clamped = 1'b1;
		end else if (sine < -unit) begin
			sine = -unit;
			e.clamped = 1'b1;
		end
		cosine = longint'(root_floor(longint'(unit * unit - sine * sine)));
		p = bam_to16(atan2_bam(sine, cosine));
		if (p > 16384) p = 16384;
		if (p < -16384) p = -16384;
		e.pitch = p[15:0];
		p = bam_to16(atan2_bam(2 * (x * y + w * z), w * w + x * x - y * y - z * z));
		e.yaw = p[15:0];
		p = bam_to16(atan2_bam(2 * (y * z + w * x), w * w - x * x - y * y + z * z));
		e.roll = p[15:0];
		return e;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("angle mismatch on %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	// Receiver: random stalls, plus one long hold-off requested by the sender side.
	initial begin
		int hold;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				hold = 300;
				m_tready <= 1'b0;
				long_hold <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			// Each cycle: usually ready, otherwise ready only one time in four.
			if (($urandom_range(0, 63) < 40) || stimulus_done)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) == 0);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		euler_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (angles_pending.size() == 0) begin
				$display("unexpected result with no request outstanding");
				error_count++;
			end else begin
				want = angles_pending.pop_front();
				if ($signed(m_tdata[15:0]) != want.yaw)
					report_mismatch("yaw", $signed(m_tdata[15:0]), want.yaw);
				if ($signed(m_tdata[31:16]) != want.pitch)
					report_mismatch("pitch", $signed(m_tdata[31:16]), want.pitch);
				if ($signed(m_tdata[47:32]) != want.roll)
					report_mismatch("roll", $signed(m_tdata[47:32]), want.roll);
				if (m_tuser != want.clamped)
					report_mismatch("pitch_clamped", m_tuser, want.clamped);
			end
		end
	end

	// Watchdog: counts cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("quaternion_to_euler_zyx regression: fail");
			$finish;
		end
	end

	// Offers one request and waits until it is accepted; the expected angles are
	// queued at the accepting edge.
	task automatic send_quat(input quat_t q, input bit known, input euler_t hand);
		euler_t e;
		e = euler_from_quat(q);
		if (known && e != hand) begin
			$display("directed row disagrees with hand value for %h", q);
			error_count++;
		end
		s_tvalid <= 1'b1;
		s_tdata <= {q.z, q.y, q.x, q.w};
		do @(posedge clk); while (!s_tready);
		angles_pending.push_back(e);
	endtask

	task automatic pause_sender(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic quat_t random_quat();
		quat_t q;
		int mode;
		mode = $urandom_range(0, 9);
		q = quat_t'({$urandom, $urandom});
		if (mode < 6) begin
			// Half-scale components, each scaled into roughly [-1, 1].
			q.w = $signed(q.w) >>> 1;
			q.x = $signed(q.x) >>> 1;
			q.y = $signed(q.y) >>> 1;
			q.z = $signed(q.z) >>> 1;
		end else if (mode == 6) begin
			// Gimbal-lock neighbourhood: w = y, x = -z gives a pitch that is never negative, +90 deg at unit norm.
			q.y = q.w;
			q.z = -q.x;
		end else if (mode == 7) begin
			q.x = 16'sd0;
			q.y = 16'sd0;
		end
		return q;
	endfunction

	vector_row_t directed_rows[$];

	initial begin
		euler_t zero_e;
		quat_t q;
		int burst;
		bit hold_started;
		bit drain_started;
		zero_e = '0;
		hold_started = 1'b0;
		drain_started = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		error_count = 0;
		idle_cycles = 0;
		long_hold = 1'b0;
		stimulus_done = 1'b0;

		// Identity and all-zero quaternions give zero angles.
		directed_rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, zero_e});
		directed_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, zero_e});
		// Pure rotations by pi about each axis and about 90 degrees.
		directed_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd11585, 16'sd0, 16'sd0, -16'sd11585}, 1'b0, zero_e});
		// Negative x operand of atan2 (turn by pi) and rounding to +pi.
		directed_rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, -16'sd16384}, 1'b0, zero_e});
		// Clamping of the asin argument: non-unit norms in both directions.
		directed_rows.push_back('{'{16'sd32767, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, zero_e});
		directed_rows.push_back('{'{16'sd32767, 16'sd0, -16'sd32768, 16'sd0}, 1'b0, zero_e});
		directed_rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
			1'b0, zero_e});
		directed_rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
			1'b0, zero_e});
		directed_rows.push_back('{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768},
			1'b0, zero_e});
		directed_rows.push_back('{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, zero_e});
		// Exactly unit asin argument: no clamp flag.
		directed_rows.push_back('{'{16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192},
			1'b0, zero_e});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_quat(directed_rows[i].q, directed_rows[i].known, directed_rows[i].e);

		for (int n = 0; n < RANDOM_REQUESTS; ) begin
			if (n >= 200 && !hold_started) begin
				// Long receiver hold-off while requests keep coming, to fill the pipe.
				hold_started = 1'b1;
				long_hold <= 1'b1;
			end
			if (n >= 500 && !drain_started) begin
				// Let every outstanding result drain before going on.
				drain_started = 1'b1;
				s_tvalid <= 1'b0;
				while (angles_pending.size() != 0) @(posedge clk);
			end
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
			for (int b = 0; b < burst && n < RANDOM_REQUESTS; b++, n++) begin
				q = random_quat();
				send_quat(q, 1'b0, zero_e);
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 6));
		end
		s_tvalid <= 1'b0;
		stimulus_done = 1'b1;

		while (angles_pending.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (error_count == 0)
			$display("quaternion_to_euler_zyx regression: pass");
		else
			$display("quaternion_to_euler_zyx regression: fail");
		$finish;
	end

endmodule
